/* src/bcd_stopwatch_floating_point_top_defines.svh */
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef BCD_STOPWATCH_FLOATING_POINT_TOP_DEFINES_SVH
`define BCD_STOPWATCH_FLOATING_POINT_TOP_DEFINES_SVH

// Same-cycle implication.
`define BSW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcd_sw check failed");

// Next-cycle implication.
`define BSW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcd_sw check failed");

`endif

/* src/bcd_sw_pkg.sv */
package bcd_sw_pkg;

    localparam int NUM_DIGITS_DEF = 13;

    localparam logic [7:0] LEVEL_RESET = 8'd100;
    localparam logic [7:0] MAXB_RESET  = 8'd200;
    localparam logic [7:0] LEVEL_STEP  = 8'd5;
    localparam logic [7:0] LEVEL_FLOOR = 8'd4;
    localparam logic [3:0] BCD_NINE    = 4'd9;
    localparam logic [3:0] WINDOW_BASE = 4'd3;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_BUTTONS   = 2'd1,
        CMD_RESET_PIN = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_STOP  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_BUMP,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic walk_clear;
        logic scan_step;
        logic bump;
        logic fill_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_run;
        logic digit_not9;
        logic walk_last;
        logic fill_last;
    } dp_stat_t;

    function automatic logic [3:0] point_mask_of(input logic [3:0] shift);
        logic [3:0] mask;
        mask = 4'd0;
        if (shift < 4'd4)
        begin
            mask = 4'd1 << shift[1:0];
        end
        return mask;
    endfunction

endpackage

/* src/bcd_stopwatch_floating_point_top.sv */
// Stopwatch core with a floating decimal point.
// Input channel s_axis_*: one transfer per event. tuser carries the event kind
// (tick, start/stop pin change, reset pin change); tdata carries button levels
// and the alarm switch. Every input transfer yields exactly one output transfer.
// Output channel m_axis_*: the four shown digits, point mask, colon and
// apostrophe marks, mode and brightness, as they stand after the event.
// Button events, reset presses, spare events and ticks outside run mode go from
// the capture state through the execute state to the done state, which loads the
// output register. A tick in run mode walks the counter one digit per cycle up to
// the first digit below nine, bumps it, then refills the shown window one digit per
// cycle through the single counter read port; a counter of all nines is not bumped.
// One event is in work at a time.
// The output register holds a finished result while the receiver stalls; a new
// input is taken meanwhile, and its result waits until that register frees.
// cfg_wr_en writes max_brightness from cfg_wr_data at any clock edge.
// After rst_n: counter and window zero, reset mode, brightness 100,
// max_brightness 200, point on the leftmost digit.
module bcd_stopwatch_floating_point_top #(
    parameter int NUM_DIGITS = bcd_sw_pkg::NUM_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] start_down, [1] stop_down, [2] reset_down, [3] alarm_on, [7:4] zero
    input  logic [7:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] digit_left, [7:4] digit_mid_left, [11:8] digit_mid_right,
    // [15:12] digit_right, [19:16] point_mask, [20] colon_on,
    // [21] apostrophe_on, [23:22] mode, [31:24] brightness
    output logic [31:0] m_axis_tdata
);
    import bcd_sw_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    bcd_sw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bcd_sw_dp #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_cmd        (s_axis_tuser),
        .in_start_down (s_axis_tdata[0]),
        .in_stop_down  (s_axis_tdata[1]),
        .in_reset_down (s_axis_tdata[2]),
        .in_alarm_on   (s_axis_tdata[3]),
        .cmd           (cmd),
        .stat          (stat),
        .out_data      (m_axis_tdata)
    );

endmodule

/* src/bcd_sw_ctrl.sv */
`include "bcd_stopwatch_floating_point_top_defines.svh"

module bcd_sw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  bcd_sw_pkg::dp_stat_t   stat,
    output bcd_sw_pkg::ctrl_cmd_t  cmd
);
    import bcd_sw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = stat.tick_run ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (stat.digit_not9)
                begin
                    state_next = ST_BUMP;
                end
                else if (stat.walk_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_BUMP:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (stat.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.walk_clear = 1'b1;
                cmd.apply      = !stat.tick_run;
            end
            ST_SCAN:
            begin
                cmd.scan_step = !stat.digit_not9 && !stat.walk_last;
            end
            ST_BUMP:
            begin
                cmd.bump = 1'b1;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `BSW_ASSERT_IMP(a_no_overwrite, out_valid_reg && !out_ready, !cmd.load_out)
    `BSW_ASSERT_NXT(a_bump_then_fill, state_reg == ST_BUMP, state_reg == ST_FILL)
    `BSW_ASSERT_NXT(a_fill_then_done, state_reg == ST_FILL && stat.fill_last,
                    state_reg == ST_DONE)

endmodule

/* src/bcd_sw_dp.sv */
`include "bcd_stopwatch_floating_point_top_defines.svh"

module bcd_sw_dp #(
    parameter int NUM_DIGITS = bcd_sw_pkg::NUM_DIGITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,
    input  logic [1:0]             in_cmd,
    input  logic                   in_start_down,
    input  logic                   in_stop_down,
    input  logic                   in_reset_down,
    input  logic                   in_alarm_on,
    input  bcd_sw_pkg::ctrl_cmd_t  cmd,
    output bcd_sw_pkg::dp_stat_t   stat,
    output logic [31:0]            out_data
);
    import bcd_sw_pkg::*;

    localparam int IDX_W = $clog2(NUM_DIGITS);
    localparam int SRC_W = 5;

    logic [1:0]       cmd_reg;
    logic             start_reg;
    logic             stop_reg;
    logic             rstp_reg;
    logic             alarm_reg;

    logic [7:0]       maxb_reg;
    mode_t            mode_reg;
    mode_t            mode_next;
    logic [1:0]       mark_reg;
    logic [1:0]       mark_next;
    logic [7:0]       level_reg;
    logic [7:0]       level_next;
    logic [3:0]       shift_reg;
    logic [3:0]       shift_next;
    logic [3:0]       digit_reg [NUM_DIGITS];
    logic [3:0]       digit_next [NUM_DIGITS];
    logic [3:0]       shown_reg [4];
    logic [3:0]       shown_next [4];
    logic [IDX_W-1:0] walk_reg;
    logic [IDX_W-1:0] walk_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic [31:0]      out_reg;

    logic [SRC_W-1:0] src;
    logic             src_ok;
    logic [IDX_W-1:0] rd_idx;
    logic [3:0]       rd_digit;
    logic [SRC_W-1:0] walk_wide;
    logic [SRC_W-1:0] shift_wide;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= in_cmd;
            start_reg <= in_start_down;
            stop_reg  <= in_stop_down;
            rstp_reg  <= in_reset_down;
            alarm_reg <= in_alarm_on;
        end
        if (cmd.load_out)
        begin
            out_reg <= {level_reg, mode_reg, mark_reg, point_mask_of(shift_reg),
                        shown_reg[3], shown_reg[2], shown_reg[1], shown_reg[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxb_reg  <= MAXB_RESET;
            mode_reg  <= MODE_RESET;
            mark_reg  <= 2'd0;
            level_reg <= LEVEL_RESET;
            shift_reg <= 4'd0;
            walk_reg  <= '0;
            fill_reg  <= 2'd0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
            for (int j = 0; j < 4; j++)
            begin
                shown_reg[j] <= 4'd0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                maxb_reg <= cfg_wr_data;
            end
            mode_reg  <= mode_next;
            mark_reg  <= mark_next;
            level_reg <= level_next;
            shift_reg <= shift_next;
            walk_reg  <= walk_next;
            fill_reg  <= fill_next;
            digit_reg <= digit_next;
            shown_reg <= shown_next;
        end
    end

    assign walk_wide  = SRC_W'(walk_reg);
    assign shift_wide = {1'b0, shift_reg};
    assign src        = shift_wide + SRC_W'(fill_reg);
    assign src_ok     = src < SRC_W'(NUM_DIGITS);
    assign rd_idx     = cmd.fill_step ? src[IDX_W-1:0] : walk_reg;
    assign rd_digit   = digit_reg[rd_idx];

    assign stat.tick_run   = (cmd_reg == CMD_TICK) && (mode_reg == MODE_RUN);
    assign stat.digit_not9 = rd_digit != BCD_NINE;
    assign stat.walk_last  = walk_reg == IDX_W'(NUM_DIGITS - 1);
    assign stat.fill_last  = fill_reg == 2'd3;

    always_comb
    begin
        mode_next  = mode_reg;
        mark_next  = mark_reg;
        level_next = level_reg;
        shift_next = shift_reg;
        walk_next  = walk_reg;
        fill_next  = fill_reg;
        digit_next = digit_reg;
        shown_next = shown_reg;

        if (cmd.walk_clear)
        begin
            walk_next = '0;
            fill_next = 2'd0;
        end

        if (cmd.scan_step)
        begin
            walk_next = walk_reg + 1'b1;
        end

        if (cmd.bump)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (IDX_W'(i) < walk_reg)
                begin
                    digit_next[i] = 4'd0;
                end
                else if (IDX_W'(i) == walk_reg)
                begin
                    digit_next[i] = digit_reg[i] + 4'd1;
                end
            end
            if (walk_wide > shift_wide + SRC_W'(WINDOW_BASE))
            begin
                shift_next = 4'(walk_wide - SRC_W'(WINDOW_BASE));
            end
        end

        if (cmd.fill_step)
        begin
            shown_next[~fill_reg] = src_ok ? rd_digit : 4'd0;
            fill_next = fill_reg + 2'd1;
        end

        if (cmd.apply)
        begin
            case (cmd_reg)
                CMD_BUTTONS:
                begin
                    mark_next = {stop_reg, start_reg};
                    if (start_reg && mode_next == MODE_RESET)
                    begin
                        mode_next = MODE_RUN;
                    end
                    if (stop_reg && mode_next == MODE_RUN)
                    begin
                        mode_next = MODE_STOP;
                    end
                    if (start_reg && stop_reg && mode_next == MODE_STOP)
                    begin
                        mode_next = MODE_RUN;
                    end
                end
                CMD_RESET_PIN:
                begin
                    if (rstp_reg)
                    begin
                        if (mode_reg == MODE_RESET)
                        begin
                            if (alarm_reg)
                            begin
                                if ({1'b0, level_reg} + {1'b0, LEVEL_FLOOR} <
                                    {1'b0, maxb_reg})
                                begin
                                    level_next = level_reg + LEVEL_STEP;
                                end
                            end
                            else if (level_reg > LEVEL_FLOOR)
                            begin
                                level_next = level_reg - LEVEL_STEP;
                            end
                        end
                        mode_next  = MODE_RESET;
                        shift_next = 4'd0;
                        for (int i = 0; i < NUM_DIGITS; i++)
                        begin
                            digit_next[i] = 4'd0;
                        end
                        for (int j = 0; j < 4; j++)
                        begin
                            shown_next[j] = 4'd0;
                        end
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    assign out_data = out_reg;

    `BSW_ASSERT_NXT(a_window_fits, cmd.bump,
                    shift_wide + SRC_W'(4) <= SRC_W'(NUM_DIGITS))
    `BSW_ASSERT_NXT(a_top_digit_bcd, cmd.bump, digit_reg[NUM_DIGITS-1] <= BCD_NINE)
    `BSW_ASSERT_IMP(a_fill_in_range, cmd.fill_step, src_ok)

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bcd_sw_pkg::*;

    localparam int DIGITS = NUM_DIGITS_DEF;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] brightness;
        mode_t      mode;
        logic       apostrophe;
        logic       colon;
        logic [3:0] points;
        logic [3:0] d_right;
        logic [3:0] d_mid_right;
        logic [3:0] d_mid_left;
        logic [3:0] d_left;
    } display_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int sent_items = 0;
    int quiet_cycles = 0;

    display_t pending_displays[$];
    display_t seen_display;
    display_t due_display;

    mode_t      watch_mode;
    logic [3:0] watch_count [DIGITS];
    logic [3:0] watch_shift;
    logic [3:0] watch_points;
    logic [3:0] watch_window [4];
    logic [1:0] watch_marks;
    logic [7:0] watch_level;
    logic [7:0] watch_max;

    always #10 clk = ~clk;

    bcd_stopwatch_floating_point_top #(
        .NUM_DIGITS(DIGITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    task automatic clear_watch_count();
        for (int i = 0; i < DIGITS; i++)
        begin
            watch_count[i] = 4'd0;
        end
        for (int i = 0; i < 4; i++)
        begin
            watch_window[i] = 4'd0;
        end
        watch_shift = 4'd0;
        watch_points = 4'b0001;
    endtask

    task automatic step_watch(input logic [1:0] kind, input logic start_btn,
                              input logic stop_btn, input logic reset_btn,
                              input logic alarm, output display_t shown);
        logic full;
        logic carry;
        int   src;
        if (kind == CMD_TICK)
        begin
            if (watch_mode == MODE_RUN)
            begin
                full = 1'b1;
                for (int i = 0; i < DIGITS; i++)
                begin
                    if (watch_count[i] != BCD_NINE)
                    begin
                        full = 1'b0;
                    end
                end
                if (!full)
                begin
                    carry = 1'b1;
                    watch_count[0] = watch_count[0] + 4'd1;
                    for (int i = 0; i < DIGITS - 1 && carry; i++)
                    begin
                        carry = 1'b0;
                        if (watch_count[i] >= 4'd10)
                        begin
                            carry = 1'b1;
                            watch_count[i] = 4'd0;
                            watch_count[i + 1] = watch_count[i + 1] + 4'd1;
                            if (i + 1 > int'(watch_shift) + 3)
                            begin
                                watch_shift = watch_shift + 4'd1;
                                watch_points = (watch_shift < 4'd4) ? (4'b0001 << watch_shift)
                                                                    : 4'b0000;
                            end
                        end
                    end
                end
                for (int i = 0; i < 4; i++)
                begin
                    src = i + int'(watch_shift);
                    watch_window[3 - i] = (src < DIGITS) ? watch_count[src] : 4'd0;
                end
            end
        end
        else if (kind == CMD_BUTTONS)
        begin
            watch_marks = {stop_btn, start_btn};
            if (start_btn && watch_mode == MODE_RESET)
            begin
                watch_mode = MODE_RUN;
            end
            if (stop_btn && watch_mode == MODE_RUN)
            begin
                watch_mode = MODE_STOP;
            end
            if (start_btn && stop_btn && watch_mode == MODE_STOP)
            begin
                watch_mode = MODE_RUN;
            end
        end
        else if (kind == CMD_RESET_PIN && reset_btn)
        begin
            if (watch_mode == MODE_RESET)
            begin
                if (alarm)
                begin
                    if (int'(watch_level) + 4 < int'(watch_max))
                    begin
                        watch_level = watch_level + LEVEL_STEP;
                    end
                end
                else if (watch_level > LEVEL_FLOOR)
                begin
                    watch_level = watch_level - LEVEL_STEP;
                end
            end
            watch_mode = MODE_RESET;
            clear_watch_count();
        end
        shown.d_left      = watch_window[0];
        shown.d_mid_left  = watch_window[1];
        shown.d_mid_right = watch_window[2];
        shown.d_right     = watch_window[3];
        shown.points      = watch_points;
        shown.colon       = watch_marks[0];
        shown.apostrophe  = watch_marks[1];
        shown.mode        = watch_mode;
        shown.brightness  = watch_level;
    endtask

    task automatic send_event(input logic [1:0] kind, input logic start_btn,
                              input logic stop_btn, input logic reset_btn,
                              input logic alarm);
        display_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0000, alarm, reset_btn, stop_btn, start_btn};
        do
            @(posedge clk);
        while (!s_axis_tready);
        step_watch(kind, start_btn, stop_btn, reset_btn, alarm, want);
        pending_displays.push_back(want);
        sent_items++;
    endtask

    task automatic send_tick();
        send_event(CMD_TICK, rand_bit(), rand_bit(), rand_bit(), rand_bit());
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_displays.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_brightness(input logic [7:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        watch_max = value;
    endtask

    task automatic play_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            // start, count, then maybe stop and restart with both buttons
            send_event(CMD_BUTTONS, 1'b1, 1'b0, rand_bit(), rand_bit());
            repeat ($urandom_range(1, 60)) send_tick();
            if ($urandom_range(1))
            begin
                send_event(CMD_BUTTONS, 1'b0, 1'b1, rand_bit(), rand_bit());
                repeat ($urandom_range(0, 3)) send_tick();
                if ($urandom_range(1))
                begin
                    send_event(CMD_BUTTONS, 1'b1, 1'b1, rand_bit(), rand_bit());
                    repeat ($urandom_range(1, 40)) send_tick();
                end
            end
        end
        else if (pick < 63)
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_event(CMD_RESET_PIN, rand_bit(), rand_bit(), 1'b1, rand_bit());
                if ($urandom_range(1))
                begin
                    send_event(CMD_RESET_PIN, rand_bit(), rand_bit(), 1'b0, rand_bit());
                end
            end
        end
        else
        begin
            send_event(2'($urandom_range(3)), rand_bit(), rand_bit(), rand_bit(),
                       rand_bit());
        end
    endtask

    task automatic test_event_cases();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(CMD_SPARE, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(CMD_RESET_PIN, 1'b1, 1'b1, 1'b0, 1'b1);
        send_event(CMD_RESET_PIN, 1'b0, 1'b0, 1'b1, 1'b1);
        send_event(CMD_RESET_PIN, 1'b0, 1'b0, 1'b1, 1'b0);
        send_event(CMD_BUTTONS, 1'b1, 1'b0, 1'b0, 1'b0);
        send_event(CMD_TICK, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(CMD_TICK, 1'b0, 1'b1, 1'b0, 1'b1);
        send_event(CMD_BUTTONS, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(CMD_BUTTONS, 1'b0, 1'b1, 1'b0, 1'b0);
        send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(CMD_BUTTONS, 1'b1, 1'b1, 1'b0, 1'b0);
        send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(CMD_BUTTONS, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(CMD_RESET_PIN, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(CMD_BUTTONS, 1'b1, 1'b1, 1'b0, 1'b0);
        send_event(CMD_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(CMD_BUTTONS, 1'b0, 1'b1, 1'b0, 1'b0);
        send_event(CMD_RESET_PIN, 1'b0, 1'b0, 1'b1, 1'b0);
        send_event(CMD_SPARE, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_brightness_limits();
        send_idle_pct = 21;
        recv_stall_pct = 21;
        write_max_brightness(8'd255);
        send_event(CMD_RESET_PIN, 1'b0, 1'b0, 1'b1, 1'b0);
        repeat (33)
        begin
            send_event(CMD_RESET_PIN, rand_bit(), rand_bit(), 1'b1, 1'b1);
            if ($urandom_range(3) == 0)
            begin
                send_event(CMD_RESET_PIN, rand_bit(), rand_bit(), 1'b0, rand_bit());
            end
        end
        write_max_brightness(8'd0);
        repeat (3) send_event(CMD_RESET_PIN, 1'b0, 1'b0, 1'b1, 1'b1);
        repeat (55) send_event(CMD_RESET_PIN, rand_bit(), rand_bit(), 1'b1, 1'b0);
        // hold at the floor, then one step under a tight bound
        write_max_brightness(8'd5);
        repeat (3) send_event(CMD_RESET_PIN, 1'b0, 1'b0, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int idle_pcts [4];
        int stall_pcts [4];
        int target;
        idle_pcts  = '{0, 68, 0, 21};
        stall_pcts = '{0, 0, 68, 21};
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_max_brightness(MAXB_RESET);
                1: write_max_brightness(8'd255);
                2: write_max_brightness(8'd0);
                default: write_max_brightness(8'($urandom_range(255)));
            endcase
            send_idle_pct = idle_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            target = sent_items + 200;
            while (sent_items < target)
            begin
                play_sequence();
            end
            wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_display = display_t'(m_axis_tdata);
            if (pending_displays.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected result transfer: %h", m_axis_tdata);
                end
            end
            else
            begin
                due_display = pending_displays.pop_front();
                if (seen_display !== due_display)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected digits %0d %0d %0d %0d points %b",
                                 due_display.d_left, due_display.d_mid_left,
                                 due_display.d_mid_right, due_display.d_right,
                                 due_display.points);
                        $display("          expected colon %b apostrophe %b mode %0d brightness %0d",
                                 due_display.colon, due_display.apostrophe,
                                 due_display.mode, due_display.brightness);
                        $display("          actual   digits %0d %0d %0d %0d points %b",
                                 seen_display.d_left, seen_display.d_mid_left,
                                 seen_display.d_mid_right, seen_display.d_right,
                                 seen_display.points);
                        $display("          actual   colon %b apostrophe %b mode %0d brightness %0d",
                                 seen_display.colon, seen_display.apostrophe,
                                 seen_display.mode, seen_display.brightness);
                    end
                end
            end
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else if (rst_n)
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        watch_mode  = MODE_RESET;
        watch_marks = 2'b00;
        watch_level = LEVEL_RESET;
        watch_max   = MAXB_RESET;
        clear_watch_count();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_event_cases();
        test_brightness_limits();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_displays.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
